@@ sv/battery_voltage_trimmed_average_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the battery voltage trimmed average block.
// The property forms are compiled only outside synthesis.
// ----------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_TRIMMED_AVERAGE_MACROS_SVH
`define BATTERY_VOLTAGE_TRIMMED_AVERAGE_MACROS_SVH

`ifndef SYNTHESIS
// Property checked at every edge outside reset.
`define BVTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition in one cycle implies the consequence in the next.
`define BVTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BVTA_ASSERT(lbl, prop, msg)
`define BVTA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/bvta_pkg.sv @@
// ----------------------------------------------------------------------------
// bvta_pkg
// Shared sizes, codes, control word and status types of the block.
// ----------------------------------------------------------------------------
package bvta_pkg;

  localparam int unsigned RingDepth  = 16;
  localparam int unsigned SampleBits = 24;
  localparam int unsigned IdxBits    = $clog2(RingDepth);
  localparam int unsigned CountBits  = $clog2(RingDepth + 1);
  localparam int unsigned SumBits    = SampleBits + IdxBits;
  // Floor of log2 of the ring depth.
  localparam int unsigned DepthShift = $clog2(RingDepth + 1) - 1;
  localparam int unsigned DivCntBits = $clog2(SumBits);
  localparam int unsigned NumRegs    = 8;
  localparam int unsigned CfgIdxBits = $clog2(NumRegs);
  localparam int unsigned StepBits   = 4;
  localparam int unsigned KindBits   = 2;
  localparam int unsigned ClassBits  = 2;

  localparam logic [KindBits-1:0]  SupplyExternal = 2'd0;
  localparam logic [KindBits-1:0]  SupplyMain     = 2'd1;
  localparam logic [KindBits-1:0]  SupplyBackup   = 2'd2;
  localparam logic [ClassBits-1:0] IntervalNone   = 2'd0;
  localparam logic [ClassBits-1:0] IntervalLong   = 2'd1;
  localparam logic [ClassBits-1:0] IntervalShort  = 2'd2;

  typedef enum logic [CfgIdxBits-1:0] {
    RegMainMin,
    RegMainMax,
    RegBackupMin,
    RegBackupMax,
    RegMainShort,
    RegBackupShort,
    RegMainOff,
    RegBackupOff
  } cfg_reg_e;

  typedef struct packed {
    logic [SampleBits-1:0] main_min;
    logic [SampleBits-1:0] main_max;
    logic [SampleBits-1:0] backup_min;
    logic [SampleBits-1:0] backup_max;
    logic [SampleBits-1:0] main_short;
    logic [SampleBits-1:0] backup_short;
    logic [SampleBits-1:0] main_off;
    logic [SampleBits-1:0] backup_off;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    OpNone,
    OpIdle,
    OpStore,
    OpPrime,
    OpScan,
    OpTrim,
    OpDivInit,
    OpDivStep,
    OpDivEnd,
    OpEmpty,
    OpPush
  } dp_op_e;

  typedef enum logic [2:0] {
    CondNever,
    CondAlways,
    CondNoItem,
    CondEmpty,
    CondMore,
    CondPartial,
    CondDivMore,
    CondOutBusy
  } jump_cond_e;

  typedef struct packed {
    dp_op_e              op;
    jump_cond_e          cond;
    logic [StepBits-1:0] target;
  } ucode_word_t;

  typedef struct packed {
    logic item_valid;
    logic ring_empty;
    logic more;
    logic partial;
    logic div_more;
    logic out_busy;
  } seq_status_t;

endpackage

@@ sv/bvta_intf.sv @@
// ----------------------------------------------------------------------------
// Channel interfaces
// Sample, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface bvta_in_if;
  import bvta_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  external_present;
  logic                  main_present;
  logic                  backup_present;
  logic [SampleBits-1:0] raw_voltage;

  modport source (
    output valid, external_present, main_present, backup_present, raw_voltage,
    input  ready
  );
  modport sink (
    input  valid, external_present, main_present, backup_present, raw_voltage,
    output ready
  );
endinterface

interface bvta_out_if;
  import bvta_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] average_voltage;
  logic [KindBits-1:0]   supply_kind;
  logic                  sample_stored;
  logic [ClassBits-1:0]  interval_class;
  logic                  poweroff_low;

  modport source (
    output valid, average_voltage, supply_kind, sample_stored, interval_class,
           poweroff_low,
    input  ready
  );
  modport sink (
    input  valid, average_voltage, supply_kind, sample_stored, interval_class,
           poweroff_low,
    output ready
  );
endinterface

interface bvta_cfg_if;
  import bvta_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CfgIdxBits-1:0] index;
  logic [SampleBits-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/bvta_regs.sv @@
// ----------------------------------------------------------------------------
// bvta_regs
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module bvta_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  bvta_cfg_if.sink            cfg_i,
  output bvta_pkg::cfg_regs_t regs_o
);
  import bvta_pkg::*;

  cfg_regs_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '{main_min:     '0,
                  main_max:     '1,
                  backup_min:   '0,
                  backup_max:   '1,
                  main_short:   '0,
                  backup_short: '0,
                  main_off:     '0,
                  backup_off:   '0};
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        RegMainMin:     regs_q.main_min     <= cfg_i.data;
        RegMainMax:     regs_q.main_max     <= cfg_i.data;
        RegBackupMin:   regs_q.backup_min   <= cfg_i.data;
        RegBackupMax:   regs_q.backup_max   <= cfg_i.data;
        RegMainShort:   regs_q.main_short   <= cfg_i.data;
        RegBackupShort: regs_q.backup_short <= cfg_i.data;
        RegMainOff:     regs_q.main_off     <= cfg_i.data;
        RegBackupOff:   regs_q.backup_off   <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

@@ sv/bvta_ucode.sv @@
// ----------------------------------------------------------------------------
// bvta_ucode
// Microcode sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
module bvta_ucode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bvta_pkg::seq_status_t status_i,
  output bvta_pkg::ucode_word_t cw_o
);
  import bvta_pkg::*;

  localparam logic [StepBits-1:0] StepWait    = StepBits'(0);
  localparam logic [StepBits-1:0] StepStore   = StepBits'(1);
  localparam logic [StepBits-1:0] StepPrime   = StepBits'(2);
  localparam logic [StepBits-1:0] StepScan    = StepBits'(3);
  localparam logic [StepBits-1:0] StepBranch  = StepBits'(4);
  localparam logic [StepBits-1:0] StepTrim    = StepBits'(5);
  localparam logic [StepBits-1:0] StepDivInit = StepBits'(6);
  localparam logic [StepBits-1:0] StepDivStep = StepBits'(7);
  localparam logic [StepBits-1:0] StepDivEnd  = StepBits'(8);
  localparam logic [StepBits-1:0] StepEmpty   = StepBits'(9);
  localparam logic [StepBits-1:0] StepResult  = StepBits'(10);
  localparam logic [StepBits-1:0] StepTail    = StepBits'(11);

  // Control store. A word jumps to its target when its condition holds,
  // otherwise it falls through to the next step.
  function automatic ucode_word_t rom_word(logic [StepBits-1:0] step);
    ucode_word_t w;
    w = '{op: OpNone, cond: CondAlways, target: StepWait};
    unique case (step)
      StepWait:    w = '{op: OpIdle,    cond: CondNoItem,  target: StepWait};
      StepStore:   w = '{op: OpStore,   cond: CondNever,   target: StepWait};
      StepPrime:   w = '{op: OpPrime,   cond: CondEmpty,   target: StepEmpty};
      StepScan:    w = '{op: OpScan,    cond: CondMore,    target: StepScan};
      StepBranch:  w = '{op: OpNone,    cond: CondPartial, target: StepDivInit};
      StepTrim:    w = '{op: OpTrim,    cond: CondAlways,  target: StepResult};
      StepDivInit: w = '{op: OpDivInit, cond: CondNever,   target: StepWait};
      StepDivStep: w = '{op: OpDivStep, cond: CondDivMore, target: StepDivStep};
      StepDivEnd:  w = '{op: OpDivEnd,  cond: CondAlways,  target: StepResult};
      StepEmpty:   w = '{op: OpEmpty,   cond: CondNever,   target: StepWait};
      StepResult:  w = '{op: OpPush,    cond: CondOutBusy, target: StepResult};
      StepTail:    w = '{op: OpNone,    cond: CondAlways,  target: StepWait};
      default:     w = '{op: OpNone,    cond: CondAlways,  target: StepWait};
    endcase
    return w;
  endfunction

  logic [StepBits-1:0] pc_q, pc_d;
  ucode_word_t         cw;
  logic                taken;

  assign cw   = rom_word(pc_q);
  assign cw_o = cw;

  always_comb begin
    unique case (cw.cond)
      CondNever:   taken = 1'b0;
      CondAlways:  taken = 1'b1;
      CondNoItem:  taken = !status_i.item_valid;
      CondEmpty:   taken = status_i.ring_empty;
      CondMore:    taken = status_i.more;
      CondPartial: taken = status_i.partial;
      CondDivMore: taken = status_i.div_more;
      CondOutBusy: taken = status_i.out_busy;
      default:     taken = 1'b1;
    endcase
    pc_d = taken ? cw.target : pc_q + StepBits'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepWait;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

@@ sv/bvta_datapath.sv @@
// ----------------------------------------------------------------------------
// bvta_datapath
// Ring memory, scan accumulators, serial divider and result register.
// ----------------------------------------------------------------------------
`include "battery_voltage_trimmed_average_macros.svh"

module bvta_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bvta_pkg::ucode_word_t cw_i,
  input  bvta_pkg::cfg_regs_t   regs_i,
  output bvta_pkg::seq_status_t status_o,
  bvta_in_if.sink               item_i,
  bvta_out_if.source            result_o
);
  import bvta_pkg::*;

  localparam int unsigned MemDepth = 2 ** (IdxBits + 1);

  // Both rings share one memory; the upper address bit selects the battery.
  logic [SampleBits-1:0] ring_mem [MemDepth];
  logic [SampleBits-1:0] rd_q;

  logic                  ext_q;
  logic                  bak_q;
  logic [SampleBits-1:0] raw_q;

  logic [IdxBits-1:0]    wp_q  [2];
  logic [CountBits-1:0]  cnt_q [2];

  logic [SumBits-1:0]    sum_q;
  logic [SampleBits-1:0] lo_q;
  logic [SampleBits-1:0] hi_q;
  logic [IdxBits-1:0]    idx_q;
  logic [CountBits-1:0]  rem_q;
  logic [SumBits-1:0]    quo_q;
  logic [DivCntBits-1:0] dcnt_q;
  logic [SampleBits-1:0] avg_q;

  logic                  out_valid_q;
  logic [SampleBits-1:0] out_avg_q;
  logic [KindBits-1:0]   out_kind_q;
  logic                  out_stored_q;
  logic [ClassBits-1:0]  out_class_q;
  logic                  out_off_q;

  logic [SampleBits-1:0] vmin, vmax, short_lvl, off_lvl, clamp_lo, clamped;
  logic [CountBits-1:0]  cur_cnt, scan_next;
  logic [IdxBits:0]      waddr, raddr;
  logic                  mem_we, out_busy, push;
  logic [SumBits-1:0]    trim_diff, trim_shift;
  logic [CountBits:0]    div_shift;
  logic                  div_ge;

  always_comb begin
    vmin      = bak_q ? regs_i.backup_min   : regs_i.main_min;
    vmax      = bak_q ? regs_i.backup_max   : regs_i.main_max;
    short_lvl = bak_q ? regs_i.backup_short : regs_i.main_short;
    off_lvl   = bak_q ? regs_i.backup_off   : regs_i.main_off;
    // Lower clamp first, so a min above max leaves the max.
    clamp_lo  = (raw_q < vmin) ? vmin : raw_q;
    clamped   = (clamp_lo > vmax) ? vmax : clamp_lo;

    cur_cnt   = cnt_q[bak_q];
    scan_next = CountBits'(idx_q) + CountBits'(1);

    mem_we = (cw_i.op == OpStore) && !ext_q;
    waddr  = {bak_q, wp_q[bak_q]};
    raddr  = (cw_i.op == OpScan) ? {bak_q, idx_q + IdxBits'(1)} : {bak_q, IdxBits'(0)};

    trim_diff  = sum_q - SumBits'(lo_q) - SumBits'(hi_q);
    trim_shift = trim_diff >> DepthShift;

    div_shift = {rem_q, quo_q[SumBits-1]};
    div_ge    = div_shift >= {1'b0, cur_cnt};

    out_busy = out_valid_q && !result_o.ready;
    push     = (cw_i.op == OpPush) && !out_busy;

    status_o.item_valid = item_i.valid;
    status_o.ring_empty = (cur_cnt == '0);
    status_o.more       = scan_next < cur_cnt;
    status_o.partial    = (cur_cnt != CountBits'(RingDepth));
    status_o.div_more   = (dcnt_q != DivCntBits'(SumBits - 1));
    status_o.out_busy   = out_busy;
  end

  assign item_i.ready = (cw_i.op == OpIdle);

  assign result_o.valid           = out_valid_q;
  assign result_o.average_voltage = out_avg_q;
  assign result_o.supply_kind     = out_kind_q;
  assign result_o.sample_stored   = out_stored_q;
  assign result_o.interval_class  = out_class_q;
  assign result_o.poweroff_low    = out_off_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[waddr] <= clamped;
    end
    rd_q <= ring_mem[raddr];
  end

  // Control state: write pointers, fill counts and the result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q[0]     <= '0;
      wp_q[1]     <= '0;
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        wp_q[bak_q] <= (wp_q[bak_q] == IdxBits'(RingDepth - 1)) ? '0
                                                                : wp_q[bak_q] + IdxBits'(1);
        if (cnt_q[bak_q] != CountBits'(RingDepth)) begin
          cnt_q[bak_q] <= cnt_q[bak_q] + CountBits'(1);
        end
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cw_i.op)
      OpIdle: begin
        if (item_i.valid) begin
          ext_q <= item_i.external_present;
          bak_q <= item_i.backup_present;
          raw_q <= item_i.raw_voltage;
        end
      end
      OpStore: idx_q <= '0;
      OpScan: begin
        idx_q <= idx_q + IdxBits'(1);
        if (idx_q == '0) begin
          sum_q <= SumBits'(rd_q);
          lo_q  <= rd_q;
          hi_q  <= rd_q;
        end else begin
          sum_q <= sum_q + SumBits'(rd_q);
          if (rd_q < lo_q) lo_q <= rd_q;
          if (rd_q > hi_q) hi_q <= rd_q;
        end
      end
      OpTrim:  avg_q <= trim_shift[SampleBits-1:0];
      OpDivInit: begin
        rem_q  <= '0;
        quo_q  <= sum_q;
        dcnt_q <= '0;
      end
      OpDivStep: begin
        dcnt_q <= dcnt_q + DivCntBits'(1);
        if (div_ge) begin
          rem_q <= CountBits'(div_shift - {1'b0, cur_cnt});
          quo_q <= {quo_q[SumBits-2:0], 1'b1};
        end else begin
          rem_q <= div_shift[CountBits-1:0];
          quo_q <= {quo_q[SumBits-2:0], 1'b0};
        end
      end
      OpDivEnd: avg_q <= quo_q[SampleBits-1:0];
      OpEmpty:  avg_q <= raw_q;
      OpPush: begin
        if (!out_busy) begin
          out_avg_q    <= avg_q;
          out_kind_q   <= ext_q ? SupplyExternal : (bak_q ? SupplyBackup : SupplyMain);
          out_stored_q <= !ext_q;
          out_class_q  <= ext_q ? IntervalNone
                                : ((avg_q <= short_lvl) ? IntervalShort : IntervalLong);
          out_off_q    <= !ext_q && (avg_q < off_lvl);
        end
      end
      default: ;
    endcase
  end

  // While a ring fills, its write pointer equals its fill count.
  `BVTA_ASSERT(a_main_fill_ptr, (cnt_q[0] != CountBits'(RingDepth)) |-> (CountBits'(wp_q[0]) == cnt_q[0]), "main ring pointer and fill count disagree")
  `BVTA_ASSERT(a_backup_fill_ptr, (cnt_q[1] != CountBits'(RingDepth)) |-> (CountBits'(wp_q[1]) == cnt_q[1]), "backup ring pointer and fill count disagree")
  `BVTA_ASSERT(a_div_rem, (cw_i.op == OpDivStep) |-> (rem_q < cnt_q[bak_q]), "divider remainder not below the divisor")
  `BVTA_ASSERT_NEXT(a_div_init, cw_i.op == OpDivInit, (rem_q == '0) && (dcnt_q == '0) && (cw_i.op == OpDivStep), "divider did not start clean")

endmodule

@@ sv/battery_voltage_trimmed_average.sv @@
// ----------------------------------------------------------------------------
// battery_voltage_trimmed_average
// Per-battery sample rings with a trimmed or plain moving average.
// ----------------------------------------------------------------------------
// Each beat on the item channel is one sampling tick, and each tick gives
// exactly one beat on the result channel. Without external power the sample
// is clamped to the selected battery's limits and stored in that battery's
// sixteen-entry ring; the ring is then averaged. A full ring gives the sum
// less its smallest and largest entry, shifted right by four. A partly filled
// ring gives the sum divided by the fill count, and an empty ring passes the
// raw sample through. A microcoded sequencer steps a small datapath: the ring
// memory is read one entry per cycle, and the division is restoring, one
// quotient bit per cycle over the 28-bit sum. A tick waits at its result
// step while the result channel still holds the previous result. The next
// item is accepted while a finished result waits in the output register.
// Configuration writes are taken in any cycle and are meant to be made while
// no tick is in flight; an index past the register list is ignored.
// ----------------------------------------------------------------------------
module battery_voltage_trimmed_average (
  input logic        clk_i,
  input logic        rst_ni,
  bvta_in_if.sink    item_i,
  bvta_out_if.source result_o,
  bvta_cfg_if.sink   cfg_i
);
  import bvta_pkg::*;

  cfg_regs_t   regs;
  ucode_word_t cw;
  seq_status_t status;

  // Configuration registers: clamp limits and decision levels.
  bvta_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  // The sequencer issues one control word per cycle and branches on the
  // datapath status (item present, ring empty, scan done, ring partial, divide
  // done, and whether the output register is still occupied).
  bvta_ucode u_ucode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cw_o     (cw)
  );

  // The datapath holds both rings, the scan accumulators, the divider and
  // the result register that decouples the result channel.
  bvta_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cw_i     (cw),
    .regs_i   (regs),
    .status_o (status),
    .item_i   (item_i),
    .result_o (result_o)
  );

endmodule
